// File: src/kot_pkg.sv
// Shared constants, types and byte decode for the keyword and operator tokenizer.
package kot_pkg;

    localparam int MAX_WORD_DEF  = 9;
    localparam int SEQ_WIDTH_DEF = 32;

    localparam int TEXT_W      = 8;
    localparam int CODE_W      = 5;
    localparam int TOKEN_SEQ_W = 32;
    localparam int KW_COUNT    = 23;
    localparam int KW_MAX_LEN  = 9;

    localparam logic [TEXT_W-1:0] CHAR_EQ      = 8'h3D;
    localparam logic [TEXT_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [TEXT_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [TEXT_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [TEXT_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic KIND_OPERATOR = 1'b0;
    localparam logic KIND_KEYWORD  = 1'b1;

    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_PLUS   = 2'd1;
    localparam logic [1:0] OP_MINUS  = 2'd2;

    localparam logic [CODE_W-1:0] OP_CODE_MAX = 5'd2;
    localparam logic [CODE_W-1:0] KW_CODE_MAX = 5'd22;

    // String literals are right-justified, so the first letter is the highest byte.
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "function", "return", "namespace", "class", "var", "struct", "enum",
        "public", "private", "static", "abstract", "virtual", "override",
        "if", "else", "elseif", "for", "foreach", "while", "continue",
        "switch", "break", "case"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd6, 4'd9, 4'd5, 4'd3, 4'd6, 4'd4, 4'd6, 4'd7, 4'd6, 4'd8, 4'd7,
        4'd8, 4'd2, 4'd4, 4'd6, 4'd3, 4'd7, 4'd5, 4'd8, 4'd6, 4'd5, 4'd4
    };

    typedef struct packed {
        logic       is_newline;
        logic       is_space;
        logic       is_op;
        logic [1:0] op_code;
    } byte_info_t;

    typedef struct packed {
        logic append;
        logic clear;
    } word_cmd_t;

    function automatic byte_info_t decode_byte(input logic [TEXT_W-1:0] text);
        byte_info_t info;
        info            = '0;
        info.is_newline = (text == CHAR_NEWLINE);
        info.is_space   = (text == CHAR_SPACE);
        case (text)
            CHAR_EQ: begin
                info.is_op   = 1'b1;
                info.op_code = OP_ASSIGN;
            end
            CHAR_PLUS: begin
                info.is_op   = 1'b1;
                info.op_code = OP_PLUS;
            end
            CHAR_MINUS: begin
                info.is_op   = 1'b1;
                info.op_code = OP_MINUS;
            end
            default: begin
                info.is_op   = 1'b0;
                info.op_code = OP_ASSIGN;
            end
        endcase
        return info;
    endfunction

endpackage

// File: src/kot_word_buf.sv
// Current word storage: bytes, length and overflow flag.
module kot_word_buf import kot_pkg::*; #(
    parameter int MAX_WORD = MAX_WORD_DEF,
    parameter int LEN_W    = $clog2(MAX_WORD + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  word_cmd_t                    cmd,
    input  logic [TEXT_W-1:0]            text_byte,
    output logic [MAX_WORD*TEXT_W-1:0]   word_flat,
    output logic [LEN_W-1:0]             word_len,
    output logic                         word_too_long
);

    localparam int IDX_W = $clog2(MAX_WORD);

    logic [TEXT_W-1:0] word_mem_reg [MAX_WORD];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              too_long_reg, too_long_next;
    logic              has_room;
    logic              wr_en;

    assign has_room = (len_reg < LEN_W'(MAX_WORD));
    assign wr_en    = cmd.append && has_room;

    always_comb begin
        len_next      = len_reg;
        too_long_next = too_long_reg;
        if (cmd.clear) begin
            len_next      = '0;
            too_long_next = 1'b0;
        end else if (cmd.append) begin
            if (has_room) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                too_long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            too_long_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WORD; i++) begin
            if (wr_en && (len_reg[IDX_W-1:0] == IDX_W'(i))) begin
                word_mem_reg[i] <= text_byte;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WORD; i++) begin
            word_flat[i*TEXT_W +: TEXT_W] = word_mem_reg[i];
        end
    end

    assign word_len      = len_reg;
    assign word_too_long = too_long_reg;

endmodule

// File: src/kot_kw_match.sv
// Parallel compare of the current word against the fixed keyword list.
module kot_kw_match import kot_pkg::*; #(
    parameter int MAX_WORD = MAX_WORD_DEF,
    parameter int LEN_W    = $clog2(MAX_WORD + 1)
) (
    input  logic [MAX_WORD*TEXT_W-1:0] word_flat,
    input  logic [LEN_W-1:0]           word_len,
    input  logic                       word_too_long,
    output logic                       kw_hit,
    output logic [CODE_W-1:0]          kw_code
);

    always_comb begin
        logic eq;
        int   pos;
        kw_hit  = 1'b0;
        kw_code = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            eq = (word_len == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    pos = int'(KW_LEN[k]) - 1 - i;
                    eq  = eq && (word_flat[i*TEXT_W +: TEXT_W] ==
                                 KW_TEXT[k][pos*TEXT_W +: TEXT_W]);
                end
            end
            // Keywords are distinct, so at most one index is ever ORed in.
            if (eq && !word_too_long) begin
                kw_hit  = 1'b1;
                kw_code = kw_code | CODE_W'(k);
            end
        end
    end

endmodule

// File: src/keyword_operator_tokenizer.sv
// Top level of the keyword and operator tokenizer.
//
// Usage:
//   Source text enters one byte per beat on the s_ channel (s_valid, s_ready,
//   s_text_byte). Tokens leave on the m_ channel (m_valid, m_ready) with
//   m_token_kind (0 operator, 1 keyword), m_token_code and m_token_seq.
//   An '=', '+' or '-' byte gives an operator token at once; a space gives a
//   keyword token when the word in front of it is a keyword. Newlines, spaces
//   and operators clear the word; other bytes extend it.
//   A byte accepted is held in the input register and decoded from there,
//   and its token is loaded into the output register.
//   Throughput: one byte per cycle unless a waiting token stalls the input, set
//   by the combinational keyword compare that reads the whole word buffer in parallel.
//   Reset clears the word, the token counter and the valid flags of both pipeline registers.
//   When the receiver stalls, the token waits in the output register; a byte
//   that gives no token still passes, and input stalls only when a second
//   token would have to leave while the first is still waiting.
module keyword_operator_tokenizer import kot_pkg::*; #(
    parameter int MAX_WORD  = MAX_WORD_DEF,
    parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [TEXT_W-1:0]      s_text_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_token_kind,
    output logic [CODE_W-1:0]      m_token_code,
    output logic [TOKEN_SEQ_W-1:0] m_token_seq
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);

    logic                          in_valid_reg, in_valid_next;
    logic [TEXT_W-1:0]             in_byte_reg;
    logic [SEQ_WIDTH-1:0]          seq_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg;
    logic [CODE_W-1:0]             out_code_reg;
    logic [TOKEN_SEQ_W-1:0]        out_seq_reg;

    byte_info_t                    info;
    word_cmd_t                     cmd;
    logic [MAX_WORD*TEXT_W-1:0]    word_flat;
    logic [LEN_W-1:0]              word_len;
    logic                          word_too_long;
    logic                          kw_hit;
    logic [CODE_W-1:0]             kw_code;
    logic                          emits;
    logic                          advance;
    logic                          load;
    logic [63:0]                   seq_wide;

    assign info    = decode_byte(in_byte_reg);
    assign emits   = info.is_op || (info.is_space && kw_hit);
    assign advance = in_valid_reg && (!emits || !out_valid_reg || m_ready);
    assign load    = advance && emits;
    assign s_ready = !in_valid_reg || advance;

    assign cmd.clear  = advance && (info.is_newline || info.is_space || info.is_op);
    assign cmd.append = advance && !(info.is_newline || info.is_space || info.is_op);

    kot_word_buf #(
        .MAX_WORD (MAX_WORD),
        .LEN_W    (LEN_W)
    ) u_word_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .text_byte     (in_byte_reg),
        .word_flat     (word_flat),
        .word_len      (word_len),
        .word_too_long (word_too_long)
    );

    kot_kw_match #(
        .MAX_WORD (MAX_WORD),
        .LEN_W    (LEN_W)
    ) u_kw_match (
        .word_flat     (word_flat),
        .word_len      (word_len),
        .word_too_long (word_too_long),
        .kw_hit        (kw_hit),
        .kw_code       (kw_code)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // The token number is taken to 64 bits first so any counter width up to 64 maps onto the port.
    assign seq_wide = 64'(seq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                seq_reg <= seq_reg + SEQ_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
        if (load) begin
            out_kind_reg <= info.is_space ? KIND_KEYWORD : KIND_OPERATOR;
            out_code_reg <= info.is_space ? kw_code : CODE_W'(info.op_code);
            out_seq_reg  <= seq_wide[TOKEN_SEQ_W-1:0];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_token_kind = out_kind_reg;
    assign m_token_code = out_code_reg;
    assign m_token_seq  = out_seq_reg;

    a_op_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_token_kind == KIND_OPERATOR)) |-> (m_token_code <= OP_CODE_MAX))
        else $error("operator token carries an out-of-range code");

    a_kw_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_token_kind == KIND_KEYWORD)) |-> (m_token_code <= KW_CODE_MAX))
        else $error("keyword token carries an out-of-range code");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        word_len <= LEN_W'(MAX_WORD))
        else $error("word length exceeds the buffer depth");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        word_too_long |-> (word_len == LEN_W'(MAX_WORD)))
        else $error("overflow flag set while the buffer is not full");

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (seq_reg == $past(seq_reg) + SEQ_WIDTH'(1)))
        else $error("token counter did not advance with a token");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the keyword and operator tokenizer.
`timescale 1ns / 1ps

module tb;
    import kot_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 700;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic                   kind;
        logic [CODE_W-1:0]      code;
        logic [TOKEN_SEQ_W-1:0] seq;
    } token_t;

    typedef struct {
        logic [TEXT_W-1:0] ch;
        bit                fixed;
        token_t            tok;
    } text_row_t;

    typedef enum int {
        PACE_OPEN,
        PACE_COIN,
        PACE_PATTERN
    } pace_mode_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [TEXT_W-1:0]      s_text_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_token_kind;
    logic [CODE_W-1:0]      m_token_code;
    logic [TOKEN_SEQ_W-1:0] m_token_seq;

    keyword_operator_tokenizer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_token_code (m_token_code),
        .m_token_seq  (m_token_seq)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Keyword spellings in token code order.
    string keyword_spellings [23] = '{
        "function", "return", "namespace", "class", "var", "struct", "enum",
        "public", "private", "static", "abstract", "virtual", "override",
        "if", "else", "elseif", "for", "foreach", "while", "continue",
        "switch", "break", "case"
    };

    // Tokenizer state as the block should hold it.
    logic [TEXT_W-1:0]      word_bytes [MAX_WORD_DEF];
    int                     word_len      = 0;
    bit                     word_overflow = 1'b0;
    logic [TOKEN_SEQ_W-1:0] next_seq      = '0;

    text_row_t text_rows [$];
    text_row_t cur_row;
    token_t    pending_tokens [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;

    function automatic void scan_byte(input logic [TEXT_W-1:0] ch, output bit fires,
                                      output token_t tok);
        int    hit;
        bit    same;
        string kw;
        fires = 1'b0;
        tok   = '0;
        hit   = -1;
        case (ch)
            CHAR_NEWLINE: begin
                word_len      = 0;
                word_overflow = 1'b0;
            end
            CHAR_SPACE: begin
                if (!word_overflow && word_len != 0) begin
                    for (int k = 0; k < 23; k++) begin
                        kw = keyword_spellings[k];
                        if (hit < 0 && kw.len() == word_len) begin
                            same = 1'b1;
                            for (int i = 0; i < word_len; i++) begin
                                if (word_bytes[i] != kw[i]) same = 1'b0;
                            end
                            if (same) hit = k;
                        end
                    end
                end
                word_len      = 0;
                word_overflow = 1'b0;
                if (hit >= 0) begin
                    fires = 1'b1;
                    tok   = '{KIND_KEYWORD, CODE_W'(hit), next_seq};
                    next_seq++;
                end
            end
            CHAR_EQ, CHAR_PLUS, CHAR_MINUS: begin
                word_len      = 0;
                word_overflow = 1'b0;
                fires         = 1'b1;
                tok.kind      = KIND_OPERATOR;
                tok.seq       = next_seq;
                if (ch == CHAR_EQ) tok.code = CODE_W'(OP_ASSIGN);
                else if (ch == CHAR_PLUS) tok.code = CODE_W'(OP_PLUS);
                else tok.code = CODE_W'(OP_MINUS);
                next_seq++;
            end
            default: begin
                if (word_len < MAX_WORD_DEF) begin
                    word_bytes[word_len] = ch;
                    word_len++;
                end else begin
                    word_overflow = 1'b1;
                end
            end
        endcase
    endfunction

    task automatic add_byte(input logic [TEXT_W-1:0] ch);
        text_row_t row;
        row.ch    = ch;
        row.fixed = 1'b0;
        row.tok   = '0;
        text_rows.insert(text_rows.size(), row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_fixed(input logic [TEXT_W-1:0] ch, input logic [1:0] op,
                             input logic [TOKEN_SEQ_W-1:0] seq);
        text_row_t row;
        row.ch    = ch;
        row.fixed = 1'b1;
        row.tok   = '{KIND_OPERATOR, CODE_W'(op), seq};
        text_rows.insert(text_rows.size(), row);
    endtask

    task automatic note_mismatch(input bit have_exp, input token_t e, input token_t a);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (have_exp)
                $display({"%0t: token mismatch, expected kind %0d code %0d seq %0d,",
                          " got kind %0d code %0d seq %0d"},
                         $time, e.kind, e.code, e.seq, a.kind, a.code, a.seq);
            else
                $display("%0t: unexpected token kind %0d code %0d seq %0d",
                         $time, a.kind, a.code, a.seq);
        end
    endtask

    // Outputs are checked before the new input beat is predicted, since a token
    // never leaves at the edge that accepts its byte.
    always @(posedge aclk) begin : scoreboard
        token_t got;
        token_t exp_tok;
        bit     fires;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                got = '{m_token_kind, m_token_code, m_token_seq};
                if (pending_tokens.size() == 0) begin
                    note_mismatch(1'b0, '0, got);
                end else begin
                    exp_tok = pending_tokens.pop_front();
                    if (got.kind !== exp_tok.kind || got.code !== exp_tok.code ||
                        got.seq !== exp_tok.seq)
                        note_mismatch(1'b1, exp_tok, got);
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(s_text_byte, fires, exp_tok);
                if (cur_row.fixed)
                    pending_tokens.insert(pending_tokens.size(), cur_row.tok);
                else if (fires)
                    pending_tokens.insert(pending_tokens.size(), exp_tok);
            end
        end
    end

    pace_mode_t  pace_mode  = PACE_OPEN;
    int          pace_left  = 0;
    logic [31:0] pace_bits  = '0;

    always @(negedge aclk) begin : sink_pacing
        if (pace_left == 0) begin
            pace_mode = pace_mode_t'($urandom_range(0, 2));
            pace_left = $urandom_range(20, 80);
            pace_bits = $urandom;
        end
        pace_left--;
        case (pace_mode)
            PACE_OPEN: begin
                m_ready <= 1'b1;
            end
            PACE_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= pace_bits[0];
                pace_bits = {pace_bits[0], pace_bits[31:1]};
            end
        endcase
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int        directed_rows;
        int        pause_at;
        int        burst_left;
        int        gap;
        int        pick;
        int        len;
        string     word;
        text_row_t row;

        // Operators right after reset carry the first sequence numbers; then an
        // empty word before a space, a newline clearing a partial word, a
        // keyword, a keyword cut short by an operator, and a word that
        // overflows the buffer with the lowest and highest byte values.
        add_fixed(CHAR_EQ, OP_ASSIGN, 32'd0);
        add_fixed(CHAR_PLUS, OP_PLUS, 32'd1);
        add_fixed(CHAR_MINUS, OP_MINUS, 32'd2);
        add_text(" x\nif case=namespace");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text(" ");
        directed_rows = text_rows.size();

        // Mostly keywords, some altered, with random separators; the rest is random
        // letter words, raw byte noise or a separator alone.
        while (text_rows.size() < directed_rows + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                word = keyword_spellings[$urandom_range(0, 22)];
                case ($urandom_range(0, 9))
                    0: word.putc($urandom_range(0, word.len() - 1),
                                 TEXT_W'($urandom_range(8'h61, 8'h7A)));
                    1: word = {word, "s"};
                    2: word = word.substr(0, word.len() - 2);
                    default: ;
                endcase
                add_text(word);
            end else if (pick < 75) begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) add_byte(TEXT_W'($urandom_range(8'h61, 8'h7A)));
            end else if (pick < 88) begin
                len = $urandom_range(1, 4);
                for (int j = 0; j < len; j++) add_byte(TEXT_W'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 19))
                0, 1: add_byte(CHAR_NEWLINE);
                2: add_byte(CHAR_EQ);
                3: add_byte(CHAR_PLUS);
                4: add_byte(CHAR_MINUS);
                5: ;
                default: add_byte(CHAR_SPACE);
            endcase
        end
        pause_at = directed_rows + 350;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        burst_left = 0;
        @(negedge aclk);
        for (int i = 0; i < text_rows.size(); i++) begin
            if (i == pause_at) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending_tokens.size() != 0);
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            if (burst_left > 0) burst_left--;
            row = text_rows[i];
            s_valid     <= 1'b1;
            s_text_byte <= row.ch;
            cur_row     <= row;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
